FILE: hw/rtl/rational_arithmetic_unit_defines.svh
// assertion macros for the rational arithmetic unit
// no dependencies; included by the top level
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// implication checked in the same cycle
`define RAU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the next cycle
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/rau_pkg.sv
// shared types and constants of the rational arithmetic unit
// used by every module of the block; no dependencies
package rau_pkg;

   localparam int RAU_QUEUE_DEPTH = 2;

   typedef enum logic [3:0] {
      CMD_NORM     = 4'd0,
      CMD_ADD      = 4'd1,
      CMD_SUB      = 4'd2,
      CMD_MUL      = 4'd3,
      CMD_TRUEDIV  = 4'd4,
      CMD_FLOORDIV = 4'd5,
      CMD_MOD      = 4'd6,
      CMD_CMP      = 4'd7,
      CMD_NEG      = 4'd8,
      CMD_ABS      = 4'd9,
      CMD_POW      = 4'd10,
      CMD_TOINT    = 4'd11
   } cmd_type;

   localparam logic [1:0] CMP_EQ = 2'd0;
   localparam logic [1:0] CMP_LT = 2'd1;
   localparam logic [1:0] CMP_GT = 2'd2;

   typedef struct packed {
      logic need_x;
      logic x_is_prod;
      logic need_y;
      logic need_d;
      logic need_sdiv;
      logic floor_mode;
      logic from_a;
      logic is_mod;
      logic need_red;
      logic frac;
      logic is_cmp;
      logic is_neg;
      logic is_pow;
      logic is_int;
   } cls_type;

   typedef struct packed {
      cmd_type     cmd;
      cls_type     cls;
      logic [63:0] a_num;
      logic [63:0] a_den;
      logic [63:0] b_num;
      logic [63:0] b_den;
      logic [7:0]  pow_k;
      logic        pow_inv;
   } item_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] p;
   } mul_rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quo;
      logic [63:0] rem;
   } div_rsp_type;

endpackage

FILE: hw/rtl/rau_front.sv
// front end: takes requests, decodes the command into control flags
// depends on rau_pkg
module rau_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [3:0]        req_command,
   input  logic [63:0]       req_a_num,
   input  logic [63:0]       req_a_den,
   input  logic [63:0]       req_b_num,
   input  logic [62:0]       req_b_den,
   input  logic [7:0]        req_exponent,
   input  logic              q_full,
   output logic              q_push,
   output rau_pkg::item_type q_item
);
   import rau_pkg::*;

   logic     hold_ff, hold_in;
   item_type item_ff, item_in;
   item_type dec;
   logic     accept;

   always_comb begin
      dec         = '0;
      dec.cmd     = cmd_type'(req_command);
      dec.a_num   = req_a_num;
      dec.a_den   = req_a_den;
      dec.b_num   = req_b_num;
      dec.b_den   = {1'b0, req_b_den};
      dec.pow_inv = req_exponent[7];
      dec.pow_k   = req_exponent[7] ? 8'(~req_exponent + 8'd1) : req_exponent;
      unique case (dec.cmd)
         CMD_NORM: begin
            dec.cls.need_red = 1'b1;
            dec.cls.frac     = 1'b1;
         end
         CMD_ADD, CMD_SUB: begin
            dec.cls.need_x   = 1'b1;
            dec.cls.need_y   = 1'b1;
            dec.cls.need_d   = 1'b1;
            dec.cls.need_red = 1'b1;
            dec.cls.frac     = 1'b1;
         end
         CMD_MUL: begin
            dec.cls.need_x    = 1'b1;
            dec.cls.x_is_prod = 1'b1;
            dec.cls.need_d    = 1'b1;
            dec.cls.need_red  = 1'b1;
            dec.cls.frac      = 1'b1;
         end
         CMD_TRUEDIV: begin
            dec.cls.need_x   = 1'b1;
            dec.cls.need_y   = 1'b1;
            dec.cls.need_red = 1'b1;
            dec.cls.frac     = 1'b1;
         end
         CMD_FLOORDIV: begin
            dec.cls.need_x     = 1'b1;
            dec.cls.need_y     = 1'b1;
            dec.cls.need_sdiv  = 1'b1;
            dec.cls.floor_mode = 1'b1;
            dec.cls.is_int     = 1'b1;
         end
         CMD_MOD: begin
            dec.cls.need_x     = 1'b1;
            dec.cls.need_y     = 1'b1;
            dec.cls.need_d     = 1'b1;
            dec.cls.need_sdiv  = 1'b1;
            dec.cls.floor_mode = 1'b1;
            dec.cls.is_mod     = 1'b1;
            dec.cls.need_red   = 1'b1;
            dec.cls.frac       = 1'b1;
         end
         CMD_CMP: begin
            dec.cls.need_x = 1'b1;
            dec.cls.need_y = 1'b1;
            dec.cls.is_cmp = 1'b1;
         end
         CMD_NEG: begin
            dec.cls.frac   = 1'b1;
            dec.cls.is_neg = 1'b1;
         end
         CMD_ABS: begin
            dec.cls.need_red = 1'b1;
            dec.cls.frac     = 1'b1;
         end
         CMD_POW: begin
            dec.cls.need_red = 1'b1;
            dec.cls.frac     = 1'b1;
            dec.cls.is_pow   = 1'b1;
         end
         CMD_TOINT: begin
            dec.cls.need_sdiv = 1'b1;
            dec.cls.from_a    = 1'b1;
            dec.cls.is_int    = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign req_stall = hold_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = hold_ff && !q_full;
   assign q_item    = item_ff;
   assign hold_in   = accept || (hold_ff && !q_push);
   assign item_in   = accept ? dec : item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
      end else begin
         hold_ff <= hold_in;
      end
      item_ff <= item_in;
   end

endmodule

FILE: hw/rtl/rau_queue.sv
// short request queue between front end and back end
// depends on rau_pkg
module rau_queue #(
   parameter int DEPTH = rau_pkg::RAU_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rau_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output rau_pkg::item_type pop_item
);
   import rau_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type          ent_ff [DEPTH];
   logic [AW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]     cnt_ff, cnt_in;

   assign full      = (cnt_ff == CW'(DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_item  = ent_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : AW'(wr_ff + 1'b1);
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : AW'(rd_ff + 1'b1);
      end
      unique case ({push, pop})
         2'b10:   cnt_in = CW'(cnt_ff + 1'b1);
         2'b01:   cnt_in = CW'(cnt_ff - 1'b1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         ent_ff[wr_ff] <= push_item;
      end
   end

endmodule

FILE: hw/rtl/rau_mul.sv
// iterative 64 x 64 multiplier, low 64 bits, one 32 x 32 product per cycle
// depends on rau_pkg
module rau_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  rau_pkg::mul_req_type mreq,
   output rau_pkg::mul_rsp_type mrsp
);
   import rau_pkg::*;

   logic        busy_ff, busy_in, done_ff, done_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [63:0] a_ff, a_in, b_ff, b_in, pr_ff, pr_in, acc_ff, acc_in;
   logic [31:0] op_a, op_b;

   always_comb begin
      unique case (cnt_ff)
         2'd0: begin
            op_a = a_ff[31:0];
            op_b = b_ff[31:0];
         end
         2'd1: begin
            op_a = a_ff[31:0];
            op_b = b_ff[63:32];
         end
         default: begin
            op_a = a_ff[63:32];
            op_b = b_ff[31:0];
         end
      endcase
      pr_in   = {32'd0, op_a} * {32'd0, op_b};
      a_in    = a_ff;
      b_in    = b_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      acc_in  = acc_ff;
      if (busy_ff) begin
         cnt_in = 2'(cnt_ff + 1'b1);
         unique case (cnt_ff)
            2'd0:    acc_in = acc_ff;
            2'd1:    acc_in = pr_ff;
            default: acc_in = acc_ff + {pr_ff[31:0], 32'd0};
         endcase
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (mreq.start) begin
         a_in    = mreq.a;
         b_in    = mreq.b;
         busy_in = 1'b1;
         cnt_in  = 2'd0;
      end
   end

   assign mrsp.done = done_ff;
   assign mrsp.p    = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      pr_ff  <= pr_in;
      acc_ff <= acc_in;
   end

endmodule

FILE: hw/rtl/rau_div.sv
// restoring unsigned 64-bit divider, one quotient bit per cycle
// depends on rau_pkg
module rau_div (
   input  logic                 clock,
   input  logic                 reset,
   input  rau_pkg::div_req_type dreq,
   output rau_pkg::div_rsp_type drsp
);
   import rau_pkg::*;

   logic        busy_ff, busy_in, done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] quo_ff, quo_in, rem_ff, rem_in, dvs_ff, dvs_in;
   logic [64:0] shifted, diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[63]};
      diff    = shifted - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         quo_in = {quo_ff[62:0], !diff[64]};
         rem_in = diff[64] ? shifted[63:0] : diff[63:0];
         cnt_in = 6'(cnt_ff + 1'b1);
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (dreq.start) begin
         quo_in  = dreq.dividend;
         rem_in  = '0;
         dvs_in  = dreq.divisor;
         busy_in = 1'b1;
         cnt_in  = '0;
      end
   end

   assign drsp.done = done_ff;
   assign drsp.quo  = quo_ff;
   assign drsp.rem  = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

FILE: hw/rtl/rau_back.sv
// back end: sequencer for products, divisions, gcd reduction and powers,
// plus the result register; depends on rau_pkg, drives rau_mul and rau_div
module rau_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  rau_pkg::item_type    q_item,
   output logic                 q_pop,
   output rau_pkg::mul_req_type mreq,
   input  rau_pkg::mul_rsp_type mrsp,
   output rau_pkg::div_req_type dreq,
   input  rau_pkg::div_rsp_type drsp,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [63:0]          rsp_res_num,
   output logic [62:0]          rsp_res_den,
   output logic [63:0]          rsp_res_int,
   output logic [1:0]           rsp_cmp_code,
   output logic                 rsp_is_negative,
   output logic                 rsp_is_nonzero,
   output logic                 rsp_div_error
);
   import rau_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_NEXT = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_DIV  = 6'b001000,
      ST_GCD  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   typedef enum logic [12:0] {
      PH_X    = 13'h0001,
      PH_Y    = 13'h0002,
      PH_D    = 13'h0004,
      PH_SDIV = 13'h0008,
      PH_T    = 13'h0010,
      PH_RED  = 13'h0020,
      PH_R0   = 13'h0040,
      PH_RQN  = 13'h0080,
      PH_RQD  = 13'h0100,
      PH_POST = 13'h0200,
      PH_POWN = 13'h0400,
      PH_POWD = 13'h0800,
      PH_OUT  = 13'h1000
   } phase_type;

   typedef enum logic [2:0] {
      GM_SH   = 3'b001,
      GM_ASH  = 3'b010,
      GM_LOOP = 3'b100
   } gmode_type;

   typedef struct packed {
      item_type    it;
      logic [63:0] x, y, d, q, rm, rn, ga, gb, num, den, pm, pn;
      logic [6:0]  gk;
      logic        neg, sneg, err;
      logic [7:0]  k;
      phase_type   ph;
      gmode_type   gm;
   } dat_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] num;
      logic [62:0] den;
      logic [63:0] ires;
      logic [1:0]  cmpc;
      logic        negf;
      logic        nzf;
      logic        err;
   } out_type;

   function automatic logic [63:0] mag64(input logic [63:0] v);
      mag64 = v[63] ? 64'(-v) : v;
   endfunction

   state_type   st_ff, st_in;
   dat_type     d_ff, d_in;
   logic        rv_ff, rv_in;
   out_type     o_ff, o_in, o_new;
   logic [63:0] dd, dv, qmag, num_o, den_o;
   logic        out_load, rnd;

   always_comb begin
      dd    = d_ff.it.cls.from_a ? d_ff.it.a_num : d_ff.x;
      dv    = d_ff.it.cls.from_a ? d_ff.it.a_den : d_ff.y;
      rnd   = d_ff.it.cls.floor_mode && d_ff.sneg && (drsp.rem != '0);
      qmag  = drsp.quo + {63'd0, rnd};
      num_o = d_ff.it.cls.is_neg ? 64'(-d_ff.it.a_num) : d_ff.num;
      den_o = d_ff.it.cls.is_neg ? d_ff.it.a_den : d_ff.den;

      o_new       = '0;
      o_new.valid = 1'b1;
      o_new.err   = d_ff.err;
      if (d_ff.it.cls.frac) begin
         o_new.num  = num_o;
         o_new.den  = den_o[62:0];
         o_new.negf = num_o[63];
         o_new.nzf  = (num_o != '0);
      end
      if (d_ff.it.cls.is_int) begin
         o_new.ires = d_ff.q;
      end
      if (d_ff.it.cls.is_cmp) begin
         priority if ($signed(d_ff.x) < $signed(d_ff.y)) begin
            o_new.cmpc = CMP_LT;
         end else if ($signed(d_ff.x) > $signed(d_ff.y)) begin
            o_new.cmpc = CMP_GT;
         end else begin
            o_new.cmpc = CMP_EQ;
         end
      end
   end

   always_comb begin
      st_in    = st_ff;
      d_in     = d_ff;
      mreq     = '0;
      dreq     = '0;
      q_pop    = 1'b0;
      out_load = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               d_in.it   = q_item;
               d_in.ph   = PH_X;
               d_in.err  = 1'b0;
               d_in.q    = '0;
               d_in.k    = q_item.pow_k;
               st_in     = ST_NEXT;
            end
         end
         ST_NEXT: begin
            unique case (d_ff.ph)
               PH_X: begin
                  if (d_ff.it.cls.need_x) begin
                     mreq.start = 1'b1;
                     mreq.a     = d_ff.it.a_num;
                     mreq.b     = d_ff.it.cls.x_is_prod ? d_ff.it.b_num : d_ff.it.b_den;
                     st_in      = ST_MUL;
                  end else begin
                     d_in.ph = PH_Y;
                  end
               end
               PH_Y: begin
                  if (d_ff.it.cls.need_y) begin
                     mreq.start = 1'b1;
                     mreq.a     = d_ff.it.b_num;
                     mreq.b     = d_ff.it.a_den;
                     st_in      = ST_MUL;
                  end else begin
                     d_in.ph = PH_D;
                  end
               end
               PH_D: begin
                  if (d_ff.it.cls.need_d) begin
                     mreq.start = 1'b1;
                     mreq.a     = d_ff.it.a_den;
                     mreq.b     = d_ff.it.b_den;
                     st_in      = ST_MUL;
                  end else begin
                     d_in.ph = PH_SDIV;
                  end
               end
               PH_SDIV: begin
                  if (d_ff.it.cls.need_sdiv) begin
                     if (dv == '0) begin
                        d_in.err = 1'b1;
                        d_in.q   = '0;
                        d_in.ph  = PH_T;
                     end else begin
                        dreq.start    = 1'b1;
                        dreq.dividend = mag64(dd);
                        dreq.divisor  = mag64(dv);
                        d_in.sneg     = dd[63] ^ dv[63];
                        st_in         = ST_DIV;
                     end
                  end else begin
                     d_in.ph = PH_T;
                  end
               end
               PH_T: begin
                  if (d_ff.it.cls.is_mod) begin
                     mreq.start = 1'b1;
                     mreq.a     = d_ff.y;
                     mreq.b     = d_ff.q;
                     st_in      = ST_MUL;
                  end else begin
                     d_in.ph = PH_RED;
                  end
               end
               PH_RED: begin
                  d_in.ph = d_ff.it.cls.need_red ? PH_R0 : PH_OUT;
                  unique case (d_ff.it.cmd)
                     CMD_NORM: begin
                        d_in.rm = d_ff.it.a_num;
                        d_in.rn = d_ff.it.a_den;
                     end
                     CMD_ADD: begin
                        d_in.rm = d_ff.x + d_ff.y;
                        d_in.rn = d_ff.d;
                     end
                     CMD_SUB: begin
                        d_in.rm = d_ff.x - d_ff.y;
                        d_in.rn = d_ff.d;
                     end
                     CMD_MUL: begin
                        d_in.rm = d_ff.x;
                        d_in.rn = d_ff.d;
                     end
                     CMD_TRUEDIV: begin
                        d_in.rm = d_ff.x;
                        d_in.rn = d_ff.y;
                     end
                     CMD_MOD: begin
                        d_in.rn = d_ff.d;
                     end
                     CMD_ABS: begin
                        d_in.rm = mag64(d_ff.it.a_num);
                        d_in.rn = d_ff.it.a_den;
                     end
                     CMD_POW: begin
                        d_in.rm = d_ff.it.pow_inv ? d_ff.it.a_den : d_ff.it.a_num;
                        d_in.rn = d_ff.it.pow_inv ? d_ff.it.a_num : d_ff.it.a_den;
                     end
                     default: begin
                     end
                  endcase
               end
               PH_R0: begin
                  priority if (d_ff.rn == '0) begin
                     d_in.num = d_ff.rm;
                     d_in.den = '0;
                     d_in.ph  = PH_POST;
                  end else if (d_ff.rm == '0) begin
                     d_in.num = '0;
                     d_in.den = 64'd1;
                     d_in.ph  = PH_POST;
                  end else begin
                     d_in.neg = d_ff.rm[63] ^ d_ff.rn[63];
                     d_in.rm  = mag64(d_ff.rm);
                     d_in.rn  = mag64(d_ff.rn);
                     d_in.ga  = mag64(d_ff.rm);
                     d_in.gb  = mag64(d_ff.rn);
                     d_in.gk  = '0;
                     d_in.gm  = GM_SH;
                     st_in    = ST_GCD;
                  end
               end
               PH_POST: begin
                  if (d_ff.it.cls.is_pow) begin
                     d_in.pm = 64'd1;
                     d_in.pn = 64'd1;
                     d_in.ph = PH_POWN;
                  end else begin
                     d_in.ph = PH_OUT;
                  end
               end
               PH_POWN: begin
                  if (d_ff.k == '0) begin
                     d_in.num = d_ff.pm;
                     d_in.den = d_ff.pn;
                     d_in.ph  = PH_OUT;
                  end else begin
                     mreq.start = 1'b1;
                     mreq.a     = d_ff.pm;
                     mreq.b     = d_ff.num;
                     st_in      = ST_MUL;
                  end
               end
               PH_POWD: begin
                  mreq.start = 1'b1;
                  mreq.a     = d_ff.pn;
                  mreq.b     = d_ff.den;
                  st_in      = ST_MUL;
               end
               PH_OUT: begin
                  st_in = ST_OUT;
               end
               default: begin
                  d_in.ph = PH_OUT;
               end
            endcase
         end
         ST_MUL: begin
            if (mrsp.done) begin
               st_in = ST_NEXT;
               unique case (d_ff.ph)
                  PH_X: begin
                     d_in.x  = mrsp.p;
                     d_in.ph = PH_Y;
                  end
                  PH_Y: begin
                     d_in.y  = mrsp.p;
                     d_in.ph = PH_D;
                  end
                  PH_D: begin
                     d_in.d  = mrsp.p;
                     d_in.ph = PH_SDIV;
                  end
                  PH_T: begin
                     d_in.rm = d_ff.x - mrsp.p;
                     d_in.ph = PH_RED;
                  end
                  PH_POWN: begin
                     d_in.pm = mrsp.p;
                     d_in.ph = PH_POWD;
                  end
                  PH_POWD: begin
                     d_in.pn = mrsp.p;
                     d_in.k  = 8'(d_ff.k - 1'b1);
                     d_in.ph = PH_POWN;
                  end
                  default: begin
                     d_in.ph = PH_OUT;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (drsp.done) begin
               unique case (d_ff.ph)
                  PH_SDIV: begin
                     d_in.q  = d_ff.sneg ? 64'(-qmag) : drsp.quo;
                     d_in.ph = PH_T;
                     st_in   = ST_NEXT;
                  end
                  PH_RQN: begin
                     d_in.num      = d_ff.neg ? 64'(-drsp.quo) : drsp.quo;
                     dreq.start    = 1'b1;
                     dreq.dividend = d_ff.rn;
                     dreq.divisor  = d_ff.ga;
                     d_in.ph       = PH_RQD;
                  end
                  PH_RQD: begin
                     d_in.den = drsp.quo;
                     d_in.ph  = PH_POST;
                     st_in    = ST_NEXT;
                  end
                  default: begin
                     d_in.ph = PH_OUT;
                     st_in   = ST_NEXT;
                  end
               endcase
            end
         end
         ST_GCD: begin
            unique case (d_ff.gm)
               GM_SH: begin
                  if (!d_ff.ga[0] && !d_ff.gb[0]) begin
                     d_in.ga = {1'b0, d_ff.ga[63:1]};
                     d_in.gb = {1'b0, d_ff.gb[63:1]};
                     d_in.gk = 7'(d_ff.gk + 1'b1);
                  end else begin
                     d_in.gm = GM_ASH;
                  end
               end
               GM_ASH: begin
                  if (!d_ff.ga[0]) begin
                     d_in.ga = {1'b0, d_ff.ga[63:1]};
                  end else begin
                     d_in.gm = GM_LOOP;
                  end
               end
               GM_LOOP: begin
                  priority if (d_ff.gb == '0) begin
                     d_in.ga       = d_ff.ga << d_ff.gk;
                     dreq.start    = 1'b1;
                     dreq.dividend = d_ff.rm;
                     dreq.divisor  = d_ff.ga << d_ff.gk;
                     d_in.ph       = PH_RQN;
                     st_in         = ST_DIV;
                  end else if (!d_ff.gb[0]) begin
                     d_in.gb = {1'b0, d_ff.gb[63:1]};
                  end else if (d_ff.ga > d_ff.gb) begin
                     d_in.ga = d_ff.gb;
                     d_in.gb = d_ff.ga - d_ff.gb;
                  end else begin
                     d_in.gb = d_ff.gb - d_ff.ga;
                  end
               end
               default: begin
                  d_in.gm = GM_LOOP;
               end
            endcase
         end
         ST_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               out_load = 1'b1;
               st_in    = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   assign rv_in = out_load || (rv_ff && rsp_stall);
   assign o_in  = out_load ? o_new : o_ff;

   assign rsp_valid       = rv_ff;
   assign rsp_res_num     = o_ff.num;
   assign rsp_res_den     = o_ff.den;
   assign rsp_res_int     = o_ff.ires;
   assign rsp_cmp_code    = o_ff.cmpc;
   assign rsp_is_negative = o_ff.negf;
   assign rsp_is_nonzero  = o_ff.nzf;
   assign rsp_div_error   = o_ff.err;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
      end
      d_ff <= d_in;
      o_ff <= o_in;
   end

endmodule

FILE: hw/rtl/rational_arithmetic_unit.sv
// top level of the rational arithmetic unit: front end, queue, back end,
// multiplier and divider; depends on rau_pkg and the assertion macro header
//
//   port group  | direction | handshake         | carries
//   req_*       | in        | req_valid/stall   | command, two rationals, exponent
//   rsp_*       | out       | rsp_valid/stall   | fraction, integer, compare, flags
//
// one request at a time in the back end; reducing operations run a binary gcd
// (one step per cycle) and two divisions, and pow adds two 64-bit products
// per exponent step. the front end takes new requests while the back end
// works, until the queue and the front-end holding register are full.
// synchronous reset, no clearing pass
`include "rational_arithmetic_unit_defines.svh"
module rational_arithmetic_unit #(
   parameter int QUEUE_DEPTH = rau_pkg::RAU_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_command,
   input  logic [63:0] req_a_num,
   input  logic [63:0] req_a_den,
   input  logic [63:0] req_b_num,
   input  logic [62:0] req_b_den,
   input  logic [7:0]  req_exponent,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_res_num,
   output logic [62:0] rsp_res_den,
   output logic [63:0] rsp_res_int,
   output logic [1:0]  rsp_cmp_code,
   output logic        rsp_is_negative,
   output logic        rsp_is_nonzero,
   output logic        rsp_div_error
);
   import rau_pkg::*;

   logic        q_push, q_full, q_pop, q_valid;
   item_type    push_item, pop_item;
   mul_req_type mreq;
   mul_rsp_type mrsp;
   div_req_type dreq;
   div_rsp_type drsp;

   rau_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_command  (req_command),
      .req_a_num    (req_a_num),
      .req_a_den    (req_a_den),
      .req_b_num    (req_b_num),
      .req_b_den    (req_b_den),
      .req_exponent (req_exponent),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_item       (push_item)
   );

   rau_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (pop_item)
   );

   rau_mul u_mul (
      .clock (clock),
      .reset (reset),
      .mreq  (mreq),
      .mrsp  (mrsp)
   );

   rau_div u_div (
      .clock (clock),
      .reset (reset),
      .dreq  (dreq),
      .drsp  (drsp)
   );

   rau_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (pop_item),
      .q_pop           (q_pop),
      .mreq            (mreq),
      .mrsp            (mrsp),
      .dreq            (dreq),
      .drsp            (drsp),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_res_num     (rsp_res_num),
      .rsp_res_den     (rsp_res_den),
      .rsp_res_int     (rsp_res_int),
      .rsp_cmp_code    (rsp_cmp_code),
      .rsp_is_negative (rsp_is_negative),
      .rsp_is_nonzero  (rsp_is_nonzero),
      .rsp_div_error   (rsp_div_error)
   );

   `RAU_ASSERT_NOW(a_no_overflow, clock, reset, q_push, !q_full, "queue push while full")
   `RAU_ASSERT_NOW(a_no_underflow, clock, reset, q_pop, q_valid, "queue pop while empty")
   `RAU_ASSERT_NOW(a_err_zero_int, clock, reset, rsp_valid && rsp_div_error,
                   rsp_res_int == '0, "division error with nonzero integer")
   `RAU_ASSERT_NOW(a_neg_nonzero, clock, reset, rsp_valid && rsp_is_negative,
                   rsp_is_nonzero, "negative flag on zero numerator")

endmodule
